[src/dsc_pkg.sv]
// Shared types and constants for the sequence classifier core.
// Used by dsc_store, dfa_sequence_classifier_core and dsc_checker; no dependencies.
package dsc_pkg;

   localparam int CMD_W      = 2;
   localparam int STATE_W    = 8;
   localparam int SYM_W      = 6;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_TRANS  = 2'd0,
      CMD_WR_ACCEPT = 2'd1,
      CMD_FEED      = 2'd2,
      CMD_END       = 2'd3
   } dsc_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATE_COUNT = 2'd0,
      CSR_START_STATE = 2'd1,
      CSR_SINK_ENABLE = 2'd2,
      CSR_SINK_STATE  = 2'd3
   } dsc_csr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_END
   } dsc_state_type;

   typedef struct packed {
      logic clear;
      logic tab_we;
      logic tab_re;
      logic acc_we;
      logic acc_re;
      logic wr_present;
      logic acc_wbit;
   } dsc_store_ctl_type;

endpackage

[src/dsc_store.sv]
// Transition memory and accept-bit memory with the post-reset clearing sweep.
// Depends on dsc_pkg for the control struct.
module dsc_store #(
   parameter int MAX_STATES  = 256,
   parameter int MAX_SYMBOLS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dsc_pkg::dsc_store_ctl_type     ctl,
   input  logic [$clog2(MAX_STATES*MAX_SYMBOLS)-1:0] tab_addr,
   input  logic [$clog2(MAX_STATES)-1:0]  acc_addr,
   input  logic [dsc_pkg::STATE_W-1:0]    wr_target,
   output logic                           rd_present,
   output logic [dsc_pkg::STATE_W-1:0]    rd_target,
   output logic                           acc_bit,
   output logic                           clear_done
);

   localparam int DEPTH  = MAX_STATES * MAX_SYMBOLS;
   localparam int TAB_AW = $clog2(DEPTH);
   localparam int ACC_AW = $clog2(MAX_STATES);

   logic [dsc_pkg::STATE_W:0]   tab_mem [DEPTH];
   logic                        acc_mem [MAX_STATES];
   logic [dsc_pkg::STATE_W:0]   tab_rd_ff;
   logic                        acc_rd_ff;
   logic [TAB_AW-1:0]           clr_ff;
   logic [TAB_AW-1:0]           clr_in;
   logic                        clr_acc;

   assign clear_done = (clr_ff == TAB_AW'(DEPTH - 1));
   assign clr_acc    = (32'(clr_ff) < MAX_STATES);
   assign clr_in     = (ctl.clear && !clear_done) ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         tab_mem[clr_ff] <= '0;
      end else if (ctl.tab_we) begin
         tab_mem[tab_addr] <= {ctl.wr_present, wr_target};
      end
      if (ctl.tab_re) begin
         tab_rd_ff <= tab_mem[tab_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         if (clr_acc) begin
            acc_mem[clr_ff[ACC_AW-1:0]] <= 1'b0;
         end
      end else if (ctl.acc_we) begin
         acc_mem[acc_addr] <= ctl.acc_wbit;
      end
      if (ctl.acc_re) begin
         acc_rd_ff <= acc_mem[acc_addr];
      end
   end

   assign rd_present = tab_rd_ff[dsc_pkg::STATE_W];
   assign rd_target  = tab_rd_ff[dsc_pkg::STATE_W-1:0];
   assign acc_bit    = acc_rd_ff;

endmodule

[src/dfa_sequence_classifier_core.sv]
// Top level of the table-driven sequence classifier: walk control, registers, result stage.
// Depends on dsc_pkg and dsc_store.
//
// After reset the core sweeps its transition memory clear, one entry per cycle; req_tready
// stays low until the sweep ends, while csr writes are taken throughout. For a fed symbol
// the table entry for the current state is read from a synchronous memory and the next
// state comes from that read; a symbol that the walk ignores, after a failure or outside
// the valid states, starts no read. An end item reads the accept bit and then loads the
// result register, waiting while an untaken earlier result holds that register. One item
// is in work at a time.
module dfa_sequence_classifier_core #(
   parameter int MAX_STATES  = 256,
   parameter int MAX_SYMBOLS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // state_index[7:0], symbol[13:8], target_state[21:14], entry_present[22], accept_bit[23]
   input  logic [dsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [dsc_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], walk_failed[1], zero fill above
   output logic [dsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [dsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH  = MAX_STATES * MAX_SYMBOLS;
   localparam int TAB_AW = $clog2(DEPTH);
   localparam int ACC_AW = $clog2(MAX_STATES);

   dsc_pkg::dsc_state_type       state_ff, state_in;
   dsc_pkg::dsc_store_ctl_type   ctl;
   dsc_pkg::dsc_cmd_type         cmd;

   logic [dsc_pkg::COUNT_W-1:0]  count_ff;
   logic [dsc_pkg::STATE_W-1:0]  start_ff;
   logic                         sink_en_ff;
   logic [dsc_pkg::STATE_W-1:0]  sink_ff;

   logic [dsc_pkg::STATE_W-1:0]  cur_ff, cur_in;
   logic                         fresh_ff, fresh_in;
   logic                         failed_ff, failed_in;
   logic                         ok_ff, ok_in;
   logic                         sym_ok_ff, sym_ok_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_data_ff, rsp_data_in;

   logic [dsc_pkg::STATE_W-1:0]  sidx;
   logic [dsc_pkg::SYM_W-1:0]    sym;
   logic [dsc_pkg::STATE_W-1:0]  target;
   logic                         present;
   logic                         acc_wbit;
   logic [dsc_pkg::STATE_W-1:0]  walk_cur;
   logic                         cur_valid;
   logic                         sink_valid;
   logic                         sidx_ok;
   logic                         sym_ok;
   logic [TAB_AW-1:0]            wr_addr;
   logic [TAB_AW-1:0]            rd_addr;
   logic [TAB_AW-1:0]            tab_addr;
   logic [ACC_AW-1:0]            acc_addr;
   logic                         rd_present;
   logic [dsc_pkg::STATE_W-1:0]  rd_target;
   logic                         acc_bit;
   logic                         clear_done;
   logic                         rsp_free;

   assign cmd      = dsc_pkg::dsc_cmd_type'(req_tuser);
   assign sidx     = req_tdata[7:0];
   assign sym      = req_tdata[13:8];
   assign target   = req_tdata[21:14];
   assign present  = req_tdata[22];
   assign acc_wbit = req_tdata[23];

   assign walk_cur   = fresh_ff ? start_ff : cur_ff;
   assign cur_valid  = (32'(walk_cur) < 32'(count_ff)) && (32'(walk_cur) < MAX_STATES);
   assign sink_valid = sink_en_ff && (32'(sink_ff) < 32'(count_ff))
                       && (32'(sink_ff) < MAX_STATES);
   assign sidx_ok    = (32'(sidx) < MAX_STATES);
   assign sym_ok     = (32'(sym) < MAX_SYMBOLS);

   assign wr_addr  = TAB_AW'(TAB_AW'(sidx) * TAB_AW'(MAX_SYMBOLS)) + TAB_AW'(sym);
   assign rd_addr  = TAB_AW'(TAB_AW'(walk_cur) * TAB_AW'(MAX_SYMBOLS)) + TAB_AW'(sym);
   assign tab_addr = (cmd == dsc_pkg::CMD_FEED) ? rd_addr : wr_addr;
   assign acc_addr = (cmd == dsc_pkg::CMD_END) ? ACC_AW'(walk_cur) : ACC_AW'(sidx);

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         start_ff   <= '0;
         sink_en_ff <= 1'b0;
         sink_ff    <= '0;
      end else if (csr_we) begin
         case (dsc_pkg::dsc_csr_type'(csr_index))
            dsc_pkg::CSR_STATE_COUNT: count_ff <= csr_wdata;
            dsc_pkg::CSR_START_STATE: start_ff <= csr_wdata[dsc_pkg::STATE_W-1:0];
            dsc_pkg::CSR_SINK_ENABLE: sink_en_ff <= csr_wdata[0];
            dsc_pkg::CSR_SINK_STATE:  sink_ff <= csr_wdata[dsc_pkg::STATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      fresh_in     = fresh_ff;
      failed_in    = failed_ff;
      ok_in        = ok_ff;
      sym_ok_in    = sym_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ctl          = '0;
      ctl.wr_present = present;
      ctl.acc_wbit   = acc_wbit;
      case (state_ff)
         dsc_pkg::ST_CLEAR: begin
            ctl.clear = 1'b1;
            if (clear_done) begin
               state_in = dsc_pkg::ST_IDLE;
            end
         end
         dsc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (cmd)
                  dsc_pkg::CMD_WR_TRANS: begin
                     ctl.tab_we = sidx_ok && sym_ok;
                  end
                  dsc_pkg::CMD_WR_ACCEPT: begin
                     ctl.acc_we = sidx_ok;
                  end
                  dsc_pkg::CMD_FEED: begin
                     if (!failed_ff && cur_valid) begin
                        ctl.tab_re = 1'b1;
                        cur_in     = walk_cur;
                        fresh_in   = 1'b0;
                        sym_ok_in  = sym_ok;
                        state_in   = dsc_pkg::ST_STEP;
                     end
                  end
                  dsc_pkg::CMD_END: begin
                     ctl.acc_re = 1'b1;
                     ok_in      = !failed_ff && cur_valid;
                     state_in   = dsc_pkg::ST_END;
                  end
                  default: ;
               endcase
            end
         end
         dsc_pkg::ST_STEP: begin
            if (sym_ok_ff && rd_present) begin
               cur_in = rd_target;
            end else if (sink_valid) begin
               cur_in = sink_ff;
            end else begin
               failed_in = 1'b1;
            end
            state_in = dsc_pkg::ST_IDLE;
         end
         dsc_pkg::ST_END: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {failed_ff, ok_ff && acc_bit};
               cur_in       = '0;
               fresh_in     = 1'b1;
               failed_in    = 1'b0;
               state_in     = dsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsc_pkg::ST_CLEAR;
         cur_ff       <= '0;
         fresh_ff     <= 1'b1;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fresh_ff     <= fresh_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      sym_ok_ff   <= sym_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   dsc_store #(
      .MAX_STATES  (MAX_STATES),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .tab_addr   (tab_addr),
      .acc_addr   (acc_addr),
      .wr_target  (target),
      .rd_present (rd_present),
      .rd_target  (rd_target),
      .acc_bit    (acc_bit),
      .clear_done (clear_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dsc_pkg::RSP_DATA_W - 2){1'b0}}, rsp_data_ff};

endmodule

[src/dsc_checker.sv]
// Port-level checks for dfa_sequence_classifier_core, attached by bind.
// Depends on dsc_pkg for the command codes.
module dsc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [dsc_pkg::CMD_W-1:0]      req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("failed walk reported as accepted");

   a_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity during clearing sweep");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready
                                  && req_tuser == dsc_pkg::CMD_END, 2))
      else $error("result without an end item");

endmodule

bind dfa_sequence_classifier_core dsc_checker u_dsc_checker (.*);
